@@ sv/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, ignored while in reset.
`define ASSERT_IMPLY(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication, ignored while in reset.
`define ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_RST(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ sv/e2rpy_pkg.sv @@
// Shared widths and constants for the Euler to roll-pitch-yaw pipeline.
package e2rpy_pkg;
  localparam int ANG_W    = 16;
  localparam int PITCH_W  = 15;
  localparam int FINE_SH  = 16;
  localparam int FINE_W   = 34;
  localparam int DATA_W   = 48;
  localparam logic signed [FINE_W-1:0] PI_FINE      = 34'sd1686629713;
  localparam logic signed [FINE_W-1:0] HALF_PI_FINE = 34'sd843314856;
  localparam logic signed [FINE_W-1:0] ROUND_HALF   = 34'sd32768;

  typedef logic signed [FINE_W-1:0] fine_t;
  typedef struct packed {
    fine_t a;
    fine_t b;
    fine_t g;
  } fine3_t;
endpackage

@@ sv/euler_to_roll_pitch_yaw.sv @@
// Euler-to-roll/pitch/yaw converter: top level.
// Converts Z-Y-X Euler angles (Q3.13 radians) to roll, pitch and yaw.
// Input stream in_*: one word holds angle_z, angle_y, angle_x, 16 bits each.
// Output stream out_*: one word holds roll (16), pitch (15), yaw (16).
// Angles outside (-pi, pi] are wrapped by 2*pi first; pitch is folded into
// [-pi/2, pi/2] and yaw and roll turn by pi when cos(pitch input) < 0.
// Each word passes three registered stages in order: wrap, fold, round.
// Throughput: one word per clock while out_tready is high; each
// stage holds one word with its own valid bit and moves on when the
// stage after it is empty or advancing.
// When out_tready is low, words pile up in the three stages and in_tready
// drops once all are full; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties every stage.
module euler_to_roll_pitch_yaw (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [15:0] angle_z_in, [31:16] angle_y_in, [47:32] angle_x_in
  input  logic [e2rpy_pkg::DATA_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [15:0] roll_out, [30:16] pitch_out, [46:31] yaw_out, [47] zero
  output logic [e2rpy_pkg::DATA_W-1:0]  out_tdata
);
  import e2rpy_pkg::*;

  logic   s1_valid, s1_ready, s2_valid, s2_ready;
  fine3_t s1_data, s2_data;

  e2rpy_wrap u_wrap (
    .clk, .rst_n,
    .s_valid (in_tvalid), .s_ready (in_tready), .s_data (in_tdata),
    .m_valid (s1_valid),  .m_ready (s1_ready),  .m_data (s1_data)
  );

  e2rpy_fold u_fold (
    .clk, .rst_n,
    .s_valid (s1_valid), .s_ready (s1_ready), .s_data (s1_data),
    .m_valid (s2_valid), .m_ready (s2_ready), .m_data (s2_data)
  );

  e2rpy_round u_round (
    .clk, .rst_n,
    .s_valid (s2_valid),   .s_ready (s2_ready),   .s_data (s2_data),
    .m_valid (out_tvalid), .m_ready (out_tready), .m_data (out_tdata)
  );
endmodule

@@ sv/e2rpy_wrap.sv @@
// Stage 1: scale the Q3.13 angles to the fine grid and wrap them into (-pi, pi].
module e2rpy_wrap (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic [e2rpy_pkg::DATA_W-1:0]  s_data,
  output logic                          m_valid,
  input  logic                          m_ready,
  output e2rpy_pkg::fine3_t             m_data
);
  import e2rpy_pkg::*;

  logic   valid_r;
  fine3_t data_r, data_nxt;

  function automatic fine_t wrap(input logic [ANG_W-1:0] code);
    fine_t f;
    f = {{(FINE_W-ANG_W-FINE_SH){code[ANG_W-1]}}, code, {FINE_SH{1'b0}}};
    if (f > PI_FINE) begin
      f = f - (PI_FINE <<< 1);
    end else if (f <= -PI_FINE) begin
      f = f + (PI_FINE <<< 1);
    end
    return f;
  endfunction

  assign s_ready = !valid_r || m_ready;

  always_comb begin
    data_nxt.a = wrap(s_data[ANG_W-1:0]);
    data_nxt.b = wrap(s_data[2*ANG_W-1:ANG_W]);
    data_nxt.g = wrap(s_data[3*ANG_W-1:2*ANG_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
    if (s_ready && s_valid) begin
      data_r <= data_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;
endmodule

@@ sv/e2rpy_fold.sv @@
// Stage 2: fold pitch into [-pi/2, pi/2] and turn yaw and roll by pi when cos(b) < 0.
module e2rpy_fold (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s_valid,
  output logic               s_ready,
  input  e2rpy_pkg::fine3_t  s_data,
  output logic               m_valid,
  input  logic               m_ready,
  output e2rpy_pkg::fine3_t  m_data
);
  import e2rpy_pkg::*;

  logic   valid_r;
  fine3_t data_r, data_nxt;
  logic   cb_pos_hi, cb_neg_lo, cb_neg;

  function automatic fine_t turn(input fine_t f, input logic neg);
    fine_t r;
    r = f;
    if (neg) begin
      r = (f >= 0) ? f - PI_FINE : f + PI_FINE;
    end
    return r;
  endfunction

  assign s_ready   = !valid_r || m_ready;
  assign cb_pos_hi = s_data.b > HALF_PI_FINE;
  assign cb_neg_lo = s_data.b < -HALF_PI_FINE;
  assign cb_neg    = cb_pos_hi || cb_neg_lo;

  always_comb begin
    if (cb_pos_hi) begin
      data_nxt.b = PI_FINE - s_data.b;
    end else if (cb_neg_lo) begin
      data_nxt.b = -PI_FINE - s_data.b;
    end else begin
      data_nxt.b = s_data.b;
    end
    data_nxt.a = turn(s_data.a, cb_neg);
    data_nxt.g = turn(s_data.g, cb_neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
    if (s_ready && s_valid) begin
      data_r <= data_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;
endmodule

@@ sv/e2rpy_round.sv @@
// Stage 3: round the fine angles half up to Q3.13 and register the output word.
module e2rpy_round (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  e2rpy_pkg::fine3_t             s_data,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic [e2rpy_pkg::DATA_W-1:0]  m_data
);
  import e2rpy_pkg::*;

  logic                valid_r;
  logic [DATA_W-1:0]   data_r, data_nxt;
  fine_t               yaw_q, pitch_q, roll_q;

  assign s_ready = !valid_r || m_ready;

  always_comb begin
    roll_q   = (s_data.g + ROUND_HALF) >>> FINE_SH;
    pitch_q  = (s_data.b + ROUND_HALF) >>> FINE_SH;
    yaw_q    = (s_data.a + ROUND_HALF) >>> FINE_SH;
    data_nxt = {1'b0, yaw_q[ANG_W-1:0], pitch_q[PITCH_W-1:0], roll_q[ANG_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
    if (s_ready && s_valid) begin
      data_r <= data_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_data  = data_r;
endmodule

@@ sv/e2rpy_checker.sv @@
// Port-level checker for the Euler-to-roll/pitch/yaw converter, with its bind.
`include "assert_macros.svh"
module e2rpy_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [e2rpy_pkg::DATA_W-1:0]  out_tdata
);
  import e2rpy_pkg::*;

  logic signed [PITCH_W-1:0] pitch;
  assign pitch = out_tdata[ANG_W+PITCH_W-1:ANG_W];

  `ASSERT_NEXT(a_hold_valid, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_NEXT_RST(a_reset_empty, !rst_n, !out_tvalid)
  `ASSERT_IMPLY(a_no_backpressure, out_tready, in_tready)
  `ASSERT_IMPLY(a_pitch_range, out_tvalid, (pitch <= 15'sd12868) && (pitch >= -15'sd12868))
endmodule

bind euler_to_roll_pitch_yaw e2rpy_checker u_e2rpy_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

@@ test/euler_to_roll_pitch_yaw_check.sv @@
// Checker: watches both streams, predicts roll/pitch/yaw and compares.
module euler_to_roll_pitch_yaw_check
  import e2rpy_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [DATA_W-1:0] out_tdata,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ANG_W-1:0]   roll;
    logic [PITCH_W-1:0] pitch;
    logic [ANG_W-1:0]   yaw;
  } attitude_t;

  attitude_t attitude_q[$];

  function automatic longint wrap_angle(logic [ANG_W-1:0] code);
    longint f;
    f = longint'($signed(code)) * 65536;
    if (f > longint'(PI_FINE)) f -= 2 * longint'(PI_FINE);
    else if (f <= -longint'(PI_FINE)) f += 2 * longint'(PI_FINE);
    return f;
  endfunction

  // Round half up to Q3.13 (floor of f + half).
  function automatic longint round_q13(longint f);
    return (f + 32768) >>> 16;
  endfunction

  function automatic longint turn_pi(longint f, bit cos_neg);
    if (!cos_neg) return f;
    return (f >= 0) ? f - longint'(PI_FINE) : f + longint'(PI_FINE);
  endfunction

  function automatic attitude_t predict_attitude(logic [DATA_W-1:0] word);
    longint a, b, g, p;
    bit cos_neg;
    attitude_t r;
    a = wrap_angle(word[15:0]);
    b = wrap_angle(word[31:16]);
    g = wrap_angle(word[47:32]);
    cos_neg = (b > longint'(HALF_PI_FINE)) || (b < -longint'(HALF_PI_FINE));
    if (b > longint'(HALF_PI_FINE)) p = longint'(PI_FINE) - b;
    else if (b < -longint'(HALF_PI_FINE)) p = -longint'(PI_FINE) - b;
    else p = b;
    r.roll  = ANG_W'(round_q13(turn_pi(g, cos_neg)));
    r.pitch = PITCH_W'(round_q13(p));
    r.yaw   = ANG_W'(round_q13(turn_pi(a, cos_neg)));
    return r;
  endfunction

  assign pending = attitude_q.size();

  always @(posedge clk) begin
    attitude_t exp_r;
    int errs;
    errs = 0;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready) attitude_q.push_back(predict_attitude(in_tdata));
      if (out_tvalid && out_tready) begin
        if (attitude_q.size() == 0) begin
          $error("result word with nothing expected: %h", out_tdata);
          errs++;
        end else begin
          exp_r = attitude_q.pop_front();
          if (out_tdata[15:0] !== exp_r.roll) begin
            $error("roll_out expected %h actual %h", exp_r.roll, out_tdata[15:0]);
            errs++;
          end
          if (out_tdata[30:16] !== exp_r.pitch) begin
            $error("pitch_out expected %h actual %h", exp_r.pitch, out_tdata[30:16]);
            errs++;
          end
          if (out_tdata[46:31] !== exp_r.yaw) begin
            $error("yaw_out expected %h actual %h", exp_r.yaw, out_tdata[46:31]);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

@@ test/euler_to_roll_pitch_yaw_test.sv @@
// Top of the testbench: clock, reset, stimulus, receiver stalls and verdict.
module euler_to_roll_pitch_yaw_test;
  import e2rpy_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1150;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [ANG_W-1:0] PI_CODE = 16'sd25736;
  localparam logic [ANG_W-1:0] HALF_PI_CODE = 16'sd12868;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  int fail_count;
  int pending;
  int cycle_count = 0;
  bit sending_done = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  euler_to_roll_pitch_yaw u_top (.*);

  euler_to_roll_pitch_yaw_check u_check (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("euler_to_roll_pitch_yaw: mismatch");
      $finish;
    end
  end

  // Random angle: mostly near the interesting points, else any 16-bit code.
  function automatic logic [ANG_W-1:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return PI_CODE + 16'($urandom_range(0, 6)) - 16'd3;
      1: return -PI_CODE + 16'($urandom_range(0, 6)) - 16'd3;
      2: return HALF_PI_CODE + 16'($urandom_range(0, 6)) - 16'd3;
      3: return -HALF_PI_CODE + 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom());
    endcase
  endfunction

  // Called right at a clock edge; returns at the edge that accepts the word.
  task automatic send_word(logic [ANG_W-1:0] az, logic [ANG_W-1:0] ay,
                           logic [ANG_W-1:0] ax);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ax, ay, az};
    do @(posedge clk); while (!in_tready);
  endtask

  // Receiver: random stalls, plus one long hold-off early on.
  initial begin
    int stall;
    repeat (10) @(posedge clk);
    repeat (40) @(posedge clk) out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
      if (stall == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
        @(posedge clk) out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [ANG_W-1:0] edge_codes[12];
    int wait_cycles;
    edge_codes = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, PI_CODE, -PI_CODE,
                   PI_CODE + 16'd1, -PI_CODE - 16'd1, HALF_PI_CODE,
                   HALF_PI_CODE + 16'd1, -HALF_PI_CODE, -HALF_PI_CODE - 16'd1};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: each extreme on pitch input, with zero and extremes elsewhere.
    foreach (edge_codes[i]) send_word(edge_codes[i], edge_codes[i], 16'h0000);
    send_word(16'h0000, PI_CODE, 16'h0000);
    send_word(16'h7FFF, 16'h8000, 16'h8000);
    for (int i = 0; i < NUM_RANDOM; i++) send_word(pick_angle(), pick_angle(), pick_angle());
    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (pending == 0 && fail_count == 0)
      $display("euler_to_roll_pitch_yaw: match");
    else
      $display("euler_to_roll_pitch_yaw: mismatch");
    $finish;
  end
endmodule
